@@ hw/rtl/twmf_pkg.sv @@
// ----------------------------------------------------------------------------
// twmf_pkg
// shared types and constants for the trie word mask filter
// ----------------------------------------------------------------------------
package twmf_pkg;

	localparam int OUT_W = 16;

	localparam logic [31:0] MASK_CHAR   = 32'd42;
	localparam logic [31:0] CASE_OFFSET = 32'd32;
	localparam logic [31:0] UPPER_A     = 32'd65;
	localparam logic [31:0] UPPER_Z     = 32'd90;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_TRUNC    = 2'd2;

	localparam logic OP_KEY  = 1'b0;
	localparam logic OP_TEXT = 1'b1;

	typedef enum logic [3:0] {
		BK_IDLE,
		BK_KSRCH,
		BK_KDONE,
		BK_TAPP,
		BK_SPOS,
		BK_SSRCH,
		BK_SNEXT,
		BK_MARK,
		BK_EMIT,
		BK_WAIT
	} bk_state_t;

	// one queued transaction from front to back
	typedef struct packed {
		logic        opcode;
		logic [31:0] ch;
		logic        upper;
		logic        fin;
	} twmf_item_t;

endpackage

@@ hw/rtl/twmf_front.sv @@
// ----------------------------------------------------------------------------
// twmf_front
// accepts input transactions, folds case and queues them for the back end
// ----------------------------------------------------------------------------
module twmf_front #(
	parameter int CHAR_BITS = 16,
	parameter int QDEPTH    = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  valid,
	output logic                  ready,
	input  logic                  opcode,
	input  logic [15:0]           char_code,
	input  logic                  final_char,
	output logic                  q_valid,
	input  logic                  q_pop,
	output twmf_pkg::twmf_item_t  q_item
);
	import twmf_pkg::*;

	localparam int AW = $clog2(QDEPTH);

	twmf_item_t        fifo_q [QDEPTH];
	logic [AW-1:0]     wr_q, rd_q;
	logic [AW:0]       cnt_q;
	logic [31:0]       c;
	logic              up;
	twmf_item_t        nitem;
	logic              push;

	always_comb begin
		c = 32'(char_code) & ((32'd1 << CHAR_BITS) - 32'd1);
		up = (c >= UPPER_A) && (c <= UPPER_Z);
		nitem.opcode = opcode;
		nitem.ch = up ? c + CASE_OFFSET : c;
		nitem.upper = up;
		nitem.fin = final_char;
	end

	assign ready = (cnt_q != (AW+1)'(QDEPTH));
	assign push = valid && ready;
	assign q_valid = (cnt_q != '0);
	assign q_item = fifo_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_q] <= nitem;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (q_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(q_pop);
		end
	end

endmodule

@@ hw/rtl/twmf_back.sv @@
// ----------------------------------------------------------------------------
// twmf_back
// trie insert, text buffering, longest-match scan and result emission
// ----------------------------------------------------------------------------
module twmf_back #(
	parameter int MAX_NODES = 1024,
	parameter int MAX_TEXT  = 64,
	parameter int CHAR_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_valid,
	output logic                  q_pop,
	input  twmf_pkg::twmf_item_t  q_item,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  result_kind,
	output logic [15:0]           out_char,
	output logic                  found_banned,
	output logic [1:0]            status,
	output logic                  run_end
);
	import twmf_pkg::*;

	localparam int NW = $clog2(MAX_NODES);
	localparam int TW = (MAX_TEXT > 1) ? $clog2(MAX_TEXT) : 1;
	localparam int LW = $clog2(MAX_TEXT + 1);

	// node table memory
	logic [NW-1:0]        npar_mem [MAX_NODES];
	logic [CHAR_BITS-1:0] nchr_mem [MAX_NODES];
	logic                 wend_mem [MAX_NODES];
	logic [NW:0]          ncount_q;
	logic [NW-1:0]        icur_q;
	logic                 iovf_q;

	// text buffer
	logic [CHAR_BITS-1:0] txt_mem [MAX_TEXT];
	logic                 upf_mem [MAX_TEXT];
	logic                 msk_mem [MAX_TEXT];
	logic [LW-1:0]        tlen_q;
	logic                 tovf_q;

	bk_state_t            st_q, st_d;
	logic [NW:0]          si_q;
	logic [NW-1:0]        rd_addr;
	logic [NW-1:0]        rpar_q;
	logic [CHAR_BITS-1:0] rchr_q;
	logic                 wrd_q;
	logic                 rvalid_q;
	logic [NW-1:0]        snode_q;
	logic [CHAR_BITS-1:0] key_q;
	logic                 kup_q;
	logic                 kfin_q;
	logic [LW-1:0]        pos_q, cur_q, best_q;
	logic                 found_q;
	logic [LW-1:0]        ek_q;
	logic [CHAR_BITS-1:0] tch_q;
	logic                 tup_q;
	logic                 tmsk_q;
	logic                 hit;
	logic                 o_load;
	logic                 o_kind_q, o_found_q, o_end_q;
	logic [15:0]          o_char_q;
	logic [1:0]           o_stat_q;
	logic                 ovalid_q;

	assign rd_addr = si_q[NW-1:0];
	assign hit = rvalid_q && (rpar_q == snode_q) && (rchr_q == key_q);
	assign o_load = ((st_q == BK_KDONE) || (st_q == BK_EMIT)) && (!ovalid_q || out_ready);

	always_ff @(posedge clk) begin
		rpar_q <= npar_mem[rd_addr];
		rchr_q <= nchr_mem[rd_addr];
		wrd_q <= wend_mem[rd_addr];
		tch_q <= txt_mem[cur_q[TW-1:0]];
		tup_q <= upf_mem[cur_q[TW-1:0]];
		tmsk_q <= msk_mem[cur_q[TW-1:0]];
	end

	assign result_kind = o_kind_q;
	assign out_char = o_char_q;
	assign found_banned = o_found_q;
	assign status = o_stat_q;
	assign run_end = o_end_q;
	assign out_valid = ovalid_q;

	always_comb begin
		st_d = st_q;
		q_pop = 1'b0;
		unique case (st_q)
			BK_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					st_d = (q_item.opcode == OP_KEY) ? BK_KSRCH : BK_TAPP;
				end
			end
			default: ;
		endcase
	end

	// single sequencer; memory writes in this clocked block
	always_ff @(posedge clk) begin
		if (st_q == BK_KSRCH && !iovf_q && !(rvalid_q && hit) &&
				!(si_q < ncount_q) && !rvalid_q &&
				ncount_q != (NW+1)'(MAX_NODES)) begin
			npar_mem[ncount_q[NW-1:0]] <= icur_q;
			nchr_mem[ncount_q[NW-1:0]] <= key_q;
			wend_mem[ncount_q[NW-1:0]] <= kfin_q;
		end
		if (st_q == BK_KSRCH && !iovf_q && rvalid_q && hit && kfin_q) begin
			wend_mem[si_q[NW-1:0] - 1'b1] <= 1'b1;
		end
		if (st_q == BK_TAPP && tlen_q != LW'(MAX_TEXT)) begin
			txt_mem[tlen_q[TW-1:0]] <= key_q;
			upf_mem[tlen_q[TW-1:0]] <= kup_q;
		end
		if (st_q == BK_SNEXT && cur_q >= tlen_q && best_q == '0) begin
			msk_mem[pos_q[TW-1:0]] <= 1'b0;
		end
		if (st_q == BK_MARK) begin
			msk_mem[pos_q[TW-1:0]] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= BK_IDLE;
			ncount_q <= (NW+1)'(1);
			icur_q <= '0;
			iovf_q <= 1'b0;
			tlen_q <= '0;
			tovf_q <= 1'b0;
			si_q <= '0;
			rvalid_q <= 1'b0;
			snode_q <= '0;
			key_q <= '0;
			kup_q <= 1'b0;
			kfin_q <= 1'b0;
			pos_q <= '0;
			cur_q <= '0;
			best_q <= '0;
			found_q <= 1'b0;
			ek_q <= '0;
			ovalid_q <= 1'b0;
			o_kind_q <= 1'b0;
			o_char_q <= '0;
			o_found_q <= 1'b0;
			o_stat_q <= ST_OK;
			o_end_q <= 1'b0;
		end else begin
			if (ovalid_q && out_ready && !o_load) begin
				ovalid_q <= 1'b0;
			end
			unique case (st_q)
				BK_IDLE: begin
					if (q_valid) begin
						key_q <= q_item.ch[CHAR_BITS-1:0];
						kup_q <= q_item.upper;
						kfin_q <= q_item.fin;
						snode_q <= icur_q;
						si_q <= (NW+1)'(1);
						rvalid_q <= 1'b0;
						st_q <= (q_item.opcode == OP_KEY) ? BK_KSRCH : BK_TAPP;
					end
				end
				BK_KSRCH: begin
					// one table read per cycle, compare in the cycle after the read
					if (iovf_q) begin
						st_q <= BK_KDONE;
					end else if (rvalid_q && hit) begin
						icur_q <= si_q[NW-1:0] - 1'b1;
						st_q <= BK_KDONE;
					end else if (si_q < ncount_q) begin
						si_q <= si_q + 1'b1;
						rvalid_q <= 1'b1;
					end else if (rvalid_q) begin
						rvalid_q <= 1'b0;
						si_q <= ncount_q + 1'b1;
					end else begin
						if (ncount_q != (NW+1)'(MAX_NODES)) begin
							icur_q <= ncount_q[NW-1:0];
							ncount_q <= ncount_q + 1'b1;
						end else begin
							iovf_q <= 1'b1;
						end
						st_q <= BK_KDONE;
					end
				end
				BK_KDONE: begin
					if (!ovalid_q || out_ready) begin
						ovalid_q <= 1'b1;
						o_kind_q <= OP_KEY;
						o_char_q <= '0;
						o_found_q <= 1'b0;
						o_stat_q <= iovf_q ? ST_FULL : ST_OK;
						o_end_q <= 1'b1;
						if (kfin_q) begin
							icur_q <= '0;
							iovf_q <= 1'b0;
						end
						st_q <= BK_IDLE;
					end
				end
				BK_TAPP: begin
					if (tlen_q != LW'(MAX_TEXT)) begin
						tlen_q <= tlen_q + 1'b1;
					end else begin
						tovf_q <= 1'b1;
					end
					if (kfin_q) begin
						pos_q <= '0;
						found_q <= 1'b0;
						st_q <= BK_SPOS;
					end else begin
						st_q <= BK_IDLE;
					end
				end
				BK_SPOS: begin
					if (pos_q >= tlen_q) begin
						ek_q <= '0;
						cur_q <= '0;
						st_q <= BK_WAIT;
					end else begin
						cur_q <= pos_q;
						snode_q <= '0;
						best_q <= '0;
						st_q <= BK_WAIT;
					end
				end
				BK_SNEXT: begin
					// tch_q now holds text at cur_q
					if (cur_q >= tlen_q) begin
						if (best_q == '0) begin
							pos_q <= pos_q + 1'b1;
							st_q <= BK_SPOS;
						end else begin
							st_q <= BK_MARK;
						end
					end else begin
						key_q <= tch_q;
						si_q <= (NW+1)'(1);
						rvalid_q <= 1'b0;
						st_q <= BK_SSRCH;
					end
				end
				BK_MARK: begin
					// one masked position per cycle
					pos_q <= pos_q + 1'b1;
					best_q <= best_q - 1'b1;
					if (best_q == LW'(1)) begin
						found_q <= 1'b1;
						st_q <= BK_SPOS;
					end
				end
				BK_SSRCH: begin
					if (rvalid_q && hit) begin
						snode_q <= si_q[NW-1:0] - 1'b1;
						if (wrd_q) best_q <= cur_q + 1'b1 - pos_q;
						cur_q <= cur_q + 1'b1;
						st_q <= BK_WAIT;
					end else if (si_q < ncount_q) begin
						si_q <= si_q + 1'b1;
						rvalid_q <= 1'b1;
					end else if (rvalid_q) begin
						rvalid_q <= 1'b0;
						si_q <= ncount_q + 1'b1;
					end else begin
						cur_q <= tlen_q;
						st_q <= BK_SNEXT;
					end
				end
				BK_WAIT: begin
					// wait for the registered text read of cur_q
					st_q <= (pos_q >= tlen_q) ? BK_EMIT : BK_SNEXT;
				end
				BK_EMIT: begin
					if (!ovalid_q || out_ready) begin
						ovalid_q <= 1'b1;
						o_kind_q <= OP_TEXT;
						o_char_q <= tmsk_q ? 16'(MASK_CHAR) :
							tup_q ? 16'(32'(tch_q) - CASE_OFFSET) :
							16'(tch_q);
						o_found_q <= found_q;
						o_stat_q <= tovf_q ? ST_TRUNC : ST_OK;
						o_end_q <= (ek_q + 1'b1 == tlen_q);
						if (ek_q + 1'b1 == tlen_q) begin
							tlen_q <= '0;
							tovf_q <= 1'b0;
							st_q <= BK_IDLE;
						end else begin
							ek_q <= ek_q + 1'b1;
							cur_q <= ek_q + 1'b1;
							st_q <= BK_WAIT;
						end
					end
				end
				default: st_q <= BK_IDLE;
			endcase
		end
	end

endmodule

@@ hw/rtl/trie_word_mask_filter.sv @@
// ----------------------------------------------------------------------------
// trie_word_mask_filter
// banned-word masking over a character trie kept in a node table
// ----------------------------------------------------------------------------
// input channel valid/ready carries opcode, char_code, final_char; output
// channel out_valid/out_ready carries one result per transaction produced.
// a keyword transaction returns one acknowledge after a linear search of the
// node table through the single table read port. text transactions are
// buffered (no result) until the final one; the scan then walks every
// buffered position, each step being a node table search, marks each masked
// character, and is followed by one result per buffered character.
// a four-entry queue separates the accepting front from the worker, so until
// it fills, input keeps being taken while the worker or receiver is stalled.
// reset empties the trie to the root alone, clears the text buffer and the
// queue; no clearing pass is needed. a stalled receiver holds the result
// register and the worker waits.
// ----------------------------------------------------------------------------
module trie_word_mask_filter #(
	parameter int MAX_NODES = 1024,
	parameter int MAX_TEXT  = 64,
	parameter int CHAR_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid,
	output logic        ready,
	input  logic        opcode,
	input  logic [15:0] char_code,
	input  logic        final_char,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        result_kind,
	output logic [15:0] out_char,
	output logic        found_banned,
	output logic [1:0]  status,
	output logic        run_end
);
	import twmf_pkg::*;

	logic       q_valid, q_pop;
	twmf_item_t q_item;

	twmf_front #(.CHAR_BITS(CHAR_BITS), .QDEPTH(4)) u_front (
		.clk(clk), .arst_n(arst_n), .valid(valid), .ready(ready),
		.opcode(opcode), .char_code(char_code), .final_char(final_char),
		.q_valid(q_valid), .q_pop(q_pop), .q_item(q_item)
	);

	twmf_back #(.MAX_NODES(MAX_NODES), .MAX_TEXT(MAX_TEXT), .CHAR_BITS(CHAR_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item),
		.out_valid(out_valid), .out_ready(out_ready), .result_kind(result_kind),
		.out_char(out_char), .found_banned(found_banned), .status(status),
		.run_end(run_end)
	);

	// acknowledges always close their run
	a_ack_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == OP_KEY |-> run_end)
		else $error("acknowledge without run_end");

	a_ack_stat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == OP_KEY |-> status != ST_TRUNC)
		else $error("acknowledge with text status");

	a_txt_stat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == OP_TEXT |-> status != ST_FULL)
		else $error("text result with table status");

endmodule

@@ verif/tb_trie_word_mask_filter.sv @@
// ----------------------------------------------------------------------------
// tb_trie_word_mask_filter
// self-checking bench for the trie word mask filter
// ----------------------------------------------------------------------------
// random keyword and text transactions drive the block; a scoreboard keeps
// its own trie and text buffer, predicts every result and compares each
// accepted output field by field, in order. sender gaps and receiver stalls
// vary by phase; one long text overruns the buffer.
// ----------------------------------------------------------------------------
class filter_scoreboard;
	typedef struct packed {
		logic        kind;
		logic [15:0] ch;
		logic        found;
		logic [1:0]  st;
		logic        last;
	} filt_result_t;

	localparam int NODES = 1024;
	localparam int TEXT  = 64;

	logic [9:0]  par [NODES];
	logic [15:0] nch [NODES];
	bit          wend [NODES];
	int          count;
	int          cursor;
	bit          kovf;
	logic [15:0] tbuf [TEXT];
	bit          tup [TEXT];
	int          tlen;
	bit          tovf;
	filt_result_t pending [$];
	int          errors;
	int          checked;
	int          masked_runs;

	function new();
		count = 1;
		cursor = 0;
		kovf = 0;
		tlen = 0;
		tovf = 0;
		errors = 0;
		checked = 0;
		masked_runs = 0;
		foreach (wend[i]) wend[i] = 0;
	endfunction

	function int child_of(int p, logic [15:0] c);
		for (int i = 1; i < count; i++)
			if (par[i] == p && nch[i] == c)
				return i;
		return -1;
	endfunction

	function int longest(int pos);
		int node;
		int best;
		node = 0;
		best = 0;
		for (int i = pos; i < tlen; i++) begin
			node = child_of(node, tbuf[i]);
			if (node < 0)
				break;
			if (wend[node])
				best = i + 1 - pos;
		end
		return best;
	endfunction

	function void note_input(logic op, logic [15:0] c, logic fin);
		filt_result_t r;
		bit up;
		logic [15:0] lc;
		up = (c >= twmf_pkg::UPPER_A[15:0]) && (c <= twmf_pkg::UPPER_Z[15:0]);
		lc = up ? c + twmf_pkg::CASE_OFFSET[15:0] : c;
		if (op == twmf_pkg::OP_KEY) begin
			int nxt;
			if (!kovf) begin
				nxt = child_of(cursor, lc);
				if (nxt < 0) begin
					if (count < NODES) begin
						nxt = count;
						par[nxt] = cursor[9:0];
						nch[nxt] = lc;
						wend[nxt] = 0;
						count++;
					end else
						kovf = 1;
				end
				if (!kovf) begin
					cursor = nxt;
					if (fin)
						wend[nxt] = 1;
				end
			end
			r = '{1'b0, 16'd0, 1'b0, kovf ? twmf_pkg::ST_FULL : twmf_pkg::ST_OK, 1'b1};
			if (fin) begin
				cursor = 0;
				kovf = 0;
			end
			pending.push_back(r);
		end else begin
			if (tlen < TEXT) begin
				tbuf[tlen] = lc;
				tup[tlen] = up;
				tlen++;
			end else
				tovf = 1;
			if (fin) begin
				bit mask [TEXT];
				bit found;
				int pos;
				int len;
				foreach (mask[i]) mask[i] = 0;
				found = 0;
				pos = 0;
				while (pos < tlen) begin
					len = longest(pos);
					if (len == 0)
						pos++;
					else begin
						for (int k = 0; k < len; k++)
							mask[pos + k] = 1;
						pos += len;
						found = 1;
					end
				end
				if (found)
					masked_runs++;
				for (int k = 0; k < tlen; k++) begin
					r.kind = 1'b1;
					r.ch = mask[k] ? twmf_pkg::MASK_CHAR[15:0] :
						tup[k] ? tbuf[k] - twmf_pkg::CASE_OFFSET[15:0] : tbuf[k];
					r.found = found;
					r.st = tovf ? twmf_pkg::ST_TRUNC : twmf_pkg::ST_OK;
					r.last = (k == tlen - 1);
					pending.push_back(r);
				end
				tlen = 0;
				tovf = 0;
			end
		end
	endfunction

	function void check_result(filt_result_t got);
		filt_result_t exp;
		checked++;
		if (pending.size() == 0) begin
			errors++;
			if (errors <= 10)
				$display("unexpected transaction: %p", got);
			return;
		end
		exp = pending.pop_front();
		if (got !== exp) begin
			errors++;
			if (errors <= 10)
				$display("mismatch: expected %p actual %p", exp, got);
		end
	endfunction
endclass

module tb_trie_word_mask_filter;
	import twmf_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        valid;
	logic        ready;
	logic        opcode;
	logic [15:0] char_code;
	logic        final_char;
	logic        out_valid;
	logic        out_ready;
	logic        result_kind;
	logic [15:0] out_char;
	logic        found_banned;
	logic [1:0]  status;
	logic        run_end;

	filter_scoreboard sb;
	int idle_pct;
	int stall_pct;
	int quiet;
	int items;
	bit timed_out;
	logic [15:0] words [8][6];
	int wlen [8];

	trie_word_mask_filter DUT (
		.clk(clk), .arst_n(arst_n), .valid(valid), .ready(ready),
		.opcode(opcode), .char_code(char_code), .final_char(final_char),
		.out_valid(out_valid), .out_ready(out_ready),
		.result_kind(result_kind), .out_char(out_char),
		.found_banned(found_banned), .status(status), .run_end(run_end)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && valid && ready) begin
			sb.note_input(opcode, char_code, final_char);
			items++;
		end
		if (arst_n && out_valid && out_ready)
			sb.check_result({result_kind, out_char, found_banned, status, run_end});
		if ((valid && ready) || (out_valid && out_ready))
			quiet = 0;
		else
			quiet++;
		if (quiet > 200000 && !timed_out) begin
			timed_out = 1;
			$display("watchdog: no transaction for %0d cycles", quiet);
			$display("trie_word_mask_filter regression: fail");
			$finish;
		end
	end

	always @(negedge clk)
		out_ready <= ($urandom_range(99) >= stall_pct);

	// valid stays high after an accept until the next gap or pause drops it
	task automatic send(logic op, logic [15:0] c, logic fin);
		while ($urandom_range(99) < idle_pct) begin
			valid <= 0;
			@(negedge clk);
		end
		valid <= 1;
		opcode <= op;
		char_code <= c;
		final_char <= fin;
		do @(posedge clk); while (!ready);
		@(negedge clk);
	endtask

	task automatic send_word(logic op, int w, bit upper);
		logic [15:0] c;
		for (int i = 0; i < wlen[w]; i++) begin
			c = words[w][i];
			if (upper && $urandom_range(1))
				c = c - 16'd32;
			send(op, c, i == wlen[w] - 1);
		end
	endtask

	task automatic wait_empty();
		valid <= 0;
		@(negedge clk);
		while (sb.pending.size() != 0)
			@(negedge clk);
	endtask

	task automatic drain();
		wait_empty();
		repeat (50) @(negedge clk);
	endtask

	function automatic logic [15:0] rand_char();
		case ($urandom_range(3))
			0: return 16'($urandom_range(16'h0061, 16'h0064));
			1: return 16'($urandom_range(16'h0041, 16'h0044));
			2: return 16'($urandom_range(16'h0040, 16'h005b));
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic random_mix(int n);
		int sel;
		int len;
		for (int j = 0; j < n; j++) begin
			sel = $urandom_range(9);
			if (sel < 2)
				send_word(OP_KEY, $urandom_range(7), 1);
			else if (sel < 7) begin
				len = $urandom_range(1, 8);
				for (int i = 0; i < len; i++) begin
					if ($urandom_range(2) == 0)
						send_word(OP_TEXT, $urandom_range(7), 1);
					else
						send(OP_TEXT, rand_char(), 0);
				end
				send(OP_TEXT, rand_char(), 1);
			end else if (sel < 9)
				send(1'($urandom_range(1)), rand_char(), 1'($urandom_range(1)));
			else begin
				send(OP_KEY, rand_char(), 1'($urandom_range(1)));
			end
		end
	endtask

	initial begin
		sb = new();
		arst_n = 0;
		valid = 0;
		opcode = OP_KEY;
		char_code = 0;
		final_char = 0;
		out_ready = 0;
		idle_pct = 0;
		stall_pct = 0;
		quiet = 0;
		items = 0;
		timed_out = 0;
		for (int w = 0; w < 8; w++) begin
			wlen[w] = $urandom_range(1, 4);
			for (int i = 0; i < 6; i++)
				words[w][i] = 16'($urandom_range(16'h0061, 16'h0064));
		end
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: keywords, overlapping words, case folding, extremes
		send(OP_KEY, 16'h0041, 0);
		send(OP_KEY, 16'h0062, 1);
		send(OP_KEY, 16'h0061, 0);
		send(OP_KEY, 16'h0062, 0);
		send(OP_KEY, 16'h0063, 1);
		send(OP_KEY, 16'hffff, 1);
		send(OP_KEY, 16'h005a, 1);
		send(OP_TEXT, 16'h0078, 0);
		send(OP_TEXT, 16'h0041, 0);
		send(OP_TEXT, 16'h0042, 0);
		send(OP_TEXT, 16'h0063, 0);
		send(OP_TEXT, 16'h0061, 0);
		send(OP_TEXT, 16'h007a, 0);
		send(OP_TEXT, 16'h0000, 0);
		send(OP_TEXT, 16'hffff, 1);
		send(OP_TEXT, 16'h0040, 1);
		send(OP_TEXT, 16'h005b, 0);
		send(OP_KEY, 16'h0061, 0);
		send(OP_TEXT, 16'h0061, 1);
		send(OP_KEY, 16'h0062, 1);
		drain();
		// text longer than the buffer
		for (int i = 0; i < 70; i++)
			send(OP_TEXT, (i % 2) ? 16'h0061 : 16'h0042, i == 69);
		drain();

		for (int w = 0; w < 4; w++)
			send_word(OP_KEY, w, 1);
		idle_pct = 0;  stall_pct = 0;  random_mix(12);
		idle_pct = 51; stall_pct = 0;  random_mix(12);
		idle_pct = 0;  stall_pct = 51; random_mix(12);
		drain();
		idle_pct = 8;  stall_pct = 8;  random_mix(12);
		drain();

		idle_pct = 0; stall_pct = 0;
		repeat (40) begin
			wait_empty();
			send(OP_TEXT, rand_char(), 1);
		end
		drain();

		$display("covered %0d input transactions, %0d results, %0d texts with masking",
			items, sb.checked, sb.masked_runs);
		$display("trie keyword insertion, case folding, longest-match masking, text truncation");
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("trie_word_mask_filter regression: pass");
		else
			$display("trie_word_mask_filter regression: fail");
		$finish;
	end
endmodule

@@ files.f @@
hw/rtl/twmf_pkg.sv
hw/rtl/twmf_front.sv
hw/rtl/twmf_back.sv
hw/rtl/trie_word_mask_filter.sv
verif/tb_trie_word_mask_filter.sv
